FILE: rtl/core/vpa_pkg.sv
// Shared types and codes for the variable partition allocator.
// Used by vpa_ctrl, vpa_datapath and variable_partition_allocator_top.
package vpa_pkg;

  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_BEST  = 2'd1;
  localparam logic [1:0] FIT_WORST = 2'd2;
  localparam logic [1:0] FIT_NEXT  = 2'd3;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic REG_FIT     = 1'b0;
  localparam logic REG_MEMSIZE = 1'b1;

  // Datapath actions.
  localparam logic [3:0] A_NONE       = 4'd0;
  localparam logic [3:0] A_LOAD       = 4'd1;
  localparam logic [3:0] A_MOD_START  = 4'd2;
  localparam logic [3:0] A_MOD_STEP   = 4'd3;
  localparam logic [3:0] A_SCAN_START = 4'd4;
  localparam logic [3:0] A_EVAL       = 4'd5;
  localparam logic [3:0] A_K_DOWN     = 4'd6;
  localparam logic [3:0] A_K_DEC      = 4'd7;
  localparam logic [3:0] A_K_INC      = 4'd8;
  localparam logic [3:0] A_MERGE_NEXT = 4'd9;
  localparam logic [3:0] A_K_AT_PICK  = 4'd10;
  localparam logic [3:0] A_COUNT_DEC  = 4'd11;
  localparam logic [3:0] A_RES_FAIL   = 4'd12;
  localparam logic [3:0] A_RES_ALLOC  = 4'd13;
  localparam logic [3:0] A_RES_FREE   = 4'd14;

  // Table read selections.
  localparam logic [2:0] RD_NONE  = 3'd0;
  localparam logic [2:0] RD_IDX   = 3'd1;
  localparam logic [2:0] RD_BELOW = 3'd2;
  localparam logic [2:0] RD_ABOVE = 3'd3;
  localparam logic [2:0] RD_NEXT  = 3'd4;
  localparam logic [2:0] RD_PREV  = 3'd5;

  // Table write selections.
  localparam logic [2:0] WR_NONE   = 3'd0;
  localparam logic [2:0] WR_TAKE   = 3'd1;
  localparam logic [2:0] WR_SHIFT  = 3'd2;
  localparam logic [2:0] WR_REMAIN = 3'd3;
  localparam logic [2:0] WR_HEAD   = 3'd4;
  localparam logic [2:0] WR_FREED  = 3'd5;
  localparam logic [2:0] WR_PREV   = 3'd6;

  typedef struct packed {
    logic [3:0] act;
    logic [2:0] rd;
    logic [2:0] wr;
  } cmd_t;

  typedef struct packed {
    logic op_free;
    logic req_zero;
    logic mod_more;
    logic eval_stop;
    logic have_pick;
    logic exact;
    logic full;
    logic shd_more;
    logic has_next;
    logic rd_free;
    logic has_prev;
    logic shu_more;
    logic out_free;
  } status_t;

endpackage

FILE: rtl/core/variable_partition_allocator_top.sv
// Top level of the variable partition allocator: sequencer plus datapath.
// Depends on vpa_pkg, vpa_ctrl and vpa_datapath.
//
//   channel  signals                                        direction
//   request  in_valid/in_ready, operation, owner_id,        in
//            request_size
//   result   out_valid/out_ready, success, start_address,   out
//            end_address, free_total
//   config   psel/penable/pwrite/paddr/pwdata/prdata/pready  APB slave
//
// One request at a time. A scan reads each table entry visited from memory,
// then compares it; a split moves entries down and a merge moves them up,
// each entry read and then written through the table's read and write ports.
// Every request but a zero-size allocation first reduces the rover modulo the
// entry count by repeated subtraction.
// Reset is synchronous and leaves one free partition of min(span, 65536).
// A finished result waits in the output register; the next request is taken
// meanwhile but the sequencer holds its own result until that transfer.
module variable_partition_allocator_top #(
  parameter int MAX_PARTITIONS = 64,
  parameter int ADDRESS_BITS   = 16,
  parameter int OWNER_BITS     = 8
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    operation,
  input  logic [OWNER_BITS-1:0]   owner_id,
  input  logic [16:0]             request_size,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    success,
  output logic [ADDRESS_BITS-1:0] start_address,
  output logic [ADDRESS_BITS-1:0] end_address,
  output logic [ADDRESS_BITS:0]   free_total,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [2:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  vpa_pkg::cmd_t    cmd;
  vpa_pkg::status_t status;

  assign pready = 1'b1;

  vpa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  vpa_datapath #(
    .MAX_PARTITIONS (MAX_PARTITIONS),
    .ADDRESS_BITS   (ADDRESS_BITS),
    .OWNER_BITS     (OWNER_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .operation     (operation),
    .owner_id      (owner_id),
    .request_size  (request_size),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .success       (success),
    .start_address (start_address),
    .end_address   (end_address),
    .free_total    (free_total),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata)
  );

  localparam logic [ADDRESS_BITS:0] SPAN_MAX = {1'b1, {ADDRESS_BITS{1'b0}}};

  // A failed result never reports an address range (checked here for failures only).
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !success |-> start_address == '0 && end_address == '0)
    else $error("failed result carries an address range");

  // Only one request is in flight.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while one is in progress");

  // The free space never exceeds the addressable span.
  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> free_total <= SPAN_MAX)
    else $error("free total above memory span");

endmodule

FILE: rtl/core/vpa_datapath.sv
// Datapath of the allocator: partition table memory, counters, config registers
// and the result register. Depends on vpa_pkg; driven by commands from vpa_ctrl.
module vpa_datapath #(
  parameter int MAX_PARTITIONS = 64,
  parameter int ADDRESS_BITS   = 16,
  parameter int OWNER_BITS     = 8
) (
  input  logic                    clk,
  input  logic                    rst,
  input  vpa_pkg::cmd_t           cmd,
  output vpa_pkg::status_t        status,
  input  logic                    operation,
  input  logic [OWNER_BITS-1:0]   owner_id,
  input  logic [16:0]             request_size,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    success,
  output logic [ADDRESS_BITS-1:0] start_address,
  output logic [ADDRESS_BITS-1:0] end_address,
  output logic [ADDRESS_BITS:0]   free_total,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [2:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata
);

  localparam int IW = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;
  localparam int NW = $clog2(MAX_PARTITIONS + 1);
  localparam int AW = ADDRESS_BITS;
  localparam int SW = ADDRESS_BITS + 1;
  localparam int RW = 17;
  localparam int CW = (SW > RW) ? SW : RW;
  localparam logic [CW-1:0] SPAN = {{(CW-1){1'b0}}, 1'b1} << AW;
  localparam logic [CW-1:0] SIZE_64K = CW'(65536);
  localparam logic [SW-1:0] RESET_SIZE = SW'((AW < 16) ? SPAN : SIZE_64K);

  typedef struct packed {
    logic [AW-1:0]         start;
    logic [SW-1:0]         size;
    logic                  free;
    logic [OWNER_BITS-1:0] owner;
  } entry_t;

  entry_t                mem [MAX_PARTITIONS];
  entry_t                rd_q;
  entry_t                pick_e;
  entry_t                wr_data;
  entry_t                init_entry;
  logic                  wr_en;
  logic [IW-1:0]         wr_addr;
  logic                  rd_en;
  logic [IW-1:0]         rd_addr;

  logic [1:0]            fit;
  logic [SW-1:0]         mem_size;
  logic [NW-1:0]         count;
  logic [IW-1:0]         rover;
  logic [IW-1:0]         r;
  logic [IW-1:0]         idx;
  logic [NW-1:0]         k;
  logic [IW-1:0]         pick;
  logic                  have_pick;
  logic [SW-1:0]         cur_size;
  logic                  op_q;
  logic [OWNER_BITS-1:0] owner_q;
  logic [RW-1:0]         req_q;
  logic [SW-1:0]         free_tot;

  logic                  cfg_wr;
  logic                  cfg_mem;
  logic                  cfg_fit;
  logic [CW-1:0]         clamp;
  logic [SW-1:0]         new_size;
  logic                  init_now;

  logic [NW-1:0]         k_below;
  logic [NW-1:0]         k_above;
  logic [NW-1:0]         pick_n;
  logic [IW-1:0]         pick_up;
  logic [IW-1:0]         pick_dn;
  logic                  fits;
  logic                  is_match;
  logic                  better;
  logic                  last;
  logic                  first_like;
  logic [SW-1:0]         free_after;
  logic                  res_load;

  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_mem = cfg_wr && (paddr[2] == vpa_pkg::REG_MEMSIZE);
  assign cfg_fit = cfg_wr && (paddr[2] == vpa_pkg::REG_FIT);

  always_comb begin
    clamp = CW'(pwdata[16:0]);
    if (clamp == '0) begin
      clamp = CW'(1);
    end
    if (clamp > SPAN) begin
      clamp = SPAN;
    end
  end

  assign new_size = SW'(clamp);
  assign init_now = rst || cfg_mem;

  always_comb begin
    init_entry       = '0;
    init_entry.size  = rst ? RESET_SIZE : new_size;
    init_entry.free  = 1'b1;
  end

  assign prdata = (paddr[2] == vpa_pkg::REG_MEMSIZE) ? 32'(mem_size) : 32'(fit);

  assign k_below = k - NW'(1);
  assign k_above = k + NW'(1);
  assign pick_n  = NW'(pick);
  assign pick_up = pick + IW'(1);
  assign pick_dn = pick - IW'(1);

  assign fits       = rd_q.free && (CW'(rd_q.size) >= CW'(req_q));
  assign is_match   = !rd_q.free && (rd_q.owner == owner_q);
  assign first_like = (fit == vpa_pkg::FIT_FIRST) || (fit == vpa_pkg::FIT_NEXT);
  assign better     = !have_pick
                   || ((fit == vpa_pkg::FIT_BEST) && (rd_q.size < pick_e.size))
                   || ((fit == vpa_pkg::FIT_WORST) && (rd_q.size > pick_e.size));
  assign last       = (k == count - NW'(1));
  assign free_after = free_tot - SW'(req_q);
  assign res_load   = (cmd.act == vpa_pkg::A_RES_FAIL)
                   || (cmd.act == vpa_pkg::A_RES_ALLOC)
                   || (cmd.act == vpa_pkg::A_RES_FREE);

  always_comb begin
    status.op_free   = (op_q == vpa_pkg::OP_FREE);
    status.req_zero  = (req_q == '0);
    status.mod_more  = (NW'(r) >= count);
    status.eval_stop = (op_q == vpa_pkg::OP_FREE) ? (is_match || last)
                                                  : ((fits && first_like) || last);
    status.have_pick = have_pick;
    status.exact     = (CW'(pick_e.size) == CW'(req_q));
    status.full      = (count == NW'(MAX_PARTITIONS));
    status.shd_more  = (k > pick_n + NW'(1));
    status.has_next  = (pick_n + NW'(1) < count);
    status.rd_free   = rd_q.free;
    status.has_prev  = (pick != '0);
    status.shu_more  = (k_above < count);
    status.out_free  = !out_valid || out_ready;
  end

  always_comb begin
    rd_en   = 1'b1;
    rd_addr = idx;
    case (cmd.rd)
      vpa_pkg::RD_IDX:   rd_addr = idx;
      vpa_pkg::RD_BELOW: rd_addr = k_below[IW-1:0];
      vpa_pkg::RD_ABOVE: rd_addr = k_above[IW-1:0];
      vpa_pkg::RD_NEXT:  rd_addr = pick_up;
      vpa_pkg::RD_PREV:  rd_addr = pick_dn;
      default:           rd_en   = 1'b0;
    endcase
  end

  always_comb begin
    wr_en   = 1'b1;
    wr_addr = pick;
    wr_data = pick_e;
    case (cmd.wr)
      vpa_pkg::WR_TAKE: begin
        wr_data.free  = 1'b0;
        wr_data.owner = owner_q;
      end
      vpa_pkg::WR_SHIFT: begin
        wr_addr = k[IW-1:0];
        wr_data = rd_q;
      end
      vpa_pkg::WR_REMAIN: begin
        wr_addr       = pick_up;
        wr_data.start = pick_e.start + AW'(req_q);
        wr_data.size  = pick_e.size - SW'(req_q);
        wr_data.free  = 1'b1;
        wr_data.owner = '0;
      end
      vpa_pkg::WR_HEAD: begin
        wr_data.size  = SW'(req_q);
        wr_data.free  = 1'b0;
        wr_data.owner = owner_q;
      end
      vpa_pkg::WR_FREED: begin
        wr_data.size  = cur_size;
        wr_data.free  = 1'b1;
        wr_data.owner = '0;
      end
      vpa_pkg::WR_PREV: begin
        wr_addr       = pick_dn;
        wr_data.start = rd_q.start;
        wr_data.size  = rd_q.size + cur_size;
        wr_data.free  = 1'b1;
        wr_data.owner = '0;
      end
      default: wr_en = 1'b0;
    endcase
  end

  // Entry 0 is rewritten at reset and on a memory size write; entries at or
  // above the count are never read before they are written.
  always_ff @(posedge clk) begin
    if (init_now) begin
      mem[0] <= init_entry;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fit       <= vpa_pkg::FIT_FIRST;
      mem_size  <= RESET_SIZE;
      count     <= NW'(1);
      rover     <= '0;
      free_tot  <= RESET_SIZE;
      out_valid <= 1'b0;
      have_pick <= 1'b0;
    end else begin
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_fit) begin
        fit <= pwdata[1:0];
      end
      if (cfg_mem) begin
        mem_size <= new_size;
        count    <= NW'(1);
        rover    <= '0;
        free_tot <= new_size;
      end
      case (cmd.act)
        vpa_pkg::A_LOAD: begin
          op_q    <= operation;
          owner_q <= owner_id;
          req_q   <= request_size;
        end
        vpa_pkg::A_MOD_START: r <= rover;
        vpa_pkg::A_MOD_STEP:  r <= IW'(NW'(r) - count);
        vpa_pkg::A_SCAN_START: begin
          idx       <= ((op_q == vpa_pkg::OP_ALLOC) && (fit == vpa_pkg::FIT_NEXT)) ? r : '0;
          k         <= '0;
          have_pick <= 1'b0;
        end
        vpa_pkg::A_EVAL: begin
          if (op_q == vpa_pkg::OP_FREE) begin
            if (is_match) begin
              pick      <= idx;
              have_pick <= 1'b1;
              pick_e    <= rd_q;
              cur_size  <= rd_q.size;
            end
          end else if (fits && better) begin
            pick      <= idx;
            have_pick <= 1'b1;
            pick_e    <= rd_q;
          end
          k   <= k + NW'(1);
          idx <= (NW'(idx) == count - NW'(1)) ? '0 : idx + IW'(1);
        end
        vpa_pkg::A_K_DOWN: k <= count;
        vpa_pkg::A_K_DEC:  k <= k_below;
        vpa_pkg::A_K_INC:  k <= k_above;
        vpa_pkg::A_MERGE_NEXT: begin
          cur_size <= cur_size + rd_q.size;
          k        <= pick_n + NW'(1);
        end
        vpa_pkg::A_K_AT_PICK: k <= pick_n;
        vpa_pkg::A_COUNT_DEC: count <= count - NW'(1);
        vpa_pkg::A_RES_FAIL: begin
          success       <= 1'b0;
          start_address <= '0;
          end_address   <= '0;
          free_total    <= free_tot;
        end
        vpa_pkg::A_RES_ALLOC: begin
          success       <= 1'b1;
          start_address <= pick_e.start;
          end_address   <= pick_e.start + AW'(req_q) - AW'(1);
          free_total    <= free_after;
          free_tot      <= free_after;
          if (CW'(pick_e.size) != CW'(req_q)) begin
            count <= count + NW'(1);
          end
          if (fit == vpa_pkg::FIT_NEXT) begin
            rover <= pick;
          end
        end
        vpa_pkg::A_RES_FREE: begin
          success       <= 1'b1;
          start_address <= '0;
          end_address   <= '0;
          free_total    <= free_tot + pick_e.size;
          free_tot      <= free_tot + pick_e.size;
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/core/vpa_ctrl.sv
// Sequencer of the allocator: scans, splits, merges and result hand-off.
// Depends on vpa_pkg; issues commands to vpa_datapath and reads its status.
module vpa_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  vpa_pkg::status_t status,
  output vpa_pkg::cmd_t    cmd
);

  localparam logic [4:0] S_IDLE      = 5'd0;
  localparam logic [4:0] S_DISPATCH  = 5'd1;
  localparam logic [4:0] S_MOD       = 5'd2;
  localparam logic [4:0] S_SRD       = 5'd3;
  localparam logic [4:0] S_SEV       = 5'd4;
  localparam logic [4:0] S_ADEC      = 5'd5;
  localparam logic [4:0] S_SHD_CHK   = 5'd6;
  localparam logic [4:0] S_SHD_WR    = 5'd7;
  localparam logic [4:0] S_HEAD      = 5'd8;
  localparam logic [4:0] S_FDEC      = 5'd9;
  localparam logic [4:0] S_F_NEV     = 5'd10;
  localparam logic [4:0] S_U_CHK     = 5'd11;
  localparam logic [4:0] S_U_WR      = 5'd12;
  localparam logic [4:0] S_F_PCHK    = 5'd13;
  localparam logic [4:0] S_F_PEV     = 5'd14;
  localparam logic [4:0] S_FIN_FAIL  = 5'd15;
  localparam logic [4:0] S_FIN_ALLOC = 5'd16;
  localparam logic [4:0] S_FIN_FREE  = 5'd17;

  logic [4:0] state;
  logic [4:0] state_next;
  logic       phase;
  logic       phase_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    phase_next = phase;
    cmd        = '{act: vpa_pkg::A_NONE, rd: vpa_pkg::RD_NONE, wr: vpa_pkg::WR_NONE};
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.act    = vpa_pkg::A_LOAD;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (!status.op_free && status.req_zero) begin
          state_next = S_FIN_FAIL;
        end else begin
          cmd.act    = vpa_pkg::A_MOD_START;
          state_next = S_MOD;
        end
      end
      S_MOD: begin
        // The rover is reduced modulo the entry count by repeated subtraction.
        if (status.mod_more) begin
          cmd.act = vpa_pkg::A_MOD_STEP;
        end else begin
          cmd.act    = vpa_pkg::A_SCAN_START;
          state_next = S_SRD;
        end
      end
      S_SRD: begin
        cmd.rd     = vpa_pkg::RD_IDX;
        state_next = S_SEV;
      end
      S_SEV: begin
        cmd.act = vpa_pkg::A_EVAL;
        if (status.eval_stop) begin
          state_next = status.op_free ? S_FDEC : S_ADEC;
        end else begin
          state_next = S_SRD;
        end
      end
      S_ADEC: begin
        if (!status.have_pick) begin
          state_next = S_FIN_FAIL;
        end else if (status.exact) begin
          cmd.wr     = vpa_pkg::WR_TAKE;
          state_next = S_FIN_ALLOC;
        end else if (status.full) begin
          state_next = S_FIN_FAIL;
        end else begin
          cmd.act    = vpa_pkg::A_K_DOWN;
          state_next = S_SHD_CHK;
        end
      end
      S_SHD_CHK: begin
        if (status.shd_more) begin
          cmd.rd     = vpa_pkg::RD_BELOW;
          state_next = S_SHD_WR;
        end else begin
          cmd.wr     = vpa_pkg::WR_REMAIN;
          state_next = S_HEAD;
        end
      end
      S_SHD_WR: begin
        cmd.wr     = vpa_pkg::WR_SHIFT;
        cmd.act    = vpa_pkg::A_K_DEC;
        state_next = S_SHD_CHK;
      end
      S_HEAD: begin
        cmd.wr     = vpa_pkg::WR_HEAD;
        state_next = S_FIN_ALLOC;
      end
      S_FDEC: begin
        if (!status.have_pick) begin
          state_next = S_FIN_FAIL;
        end else if (status.has_next) begin
          cmd.rd     = vpa_pkg::RD_NEXT;
          state_next = S_F_NEV;
        end else begin
          state_next = S_F_PCHK;
        end
      end
      S_F_NEV: begin
        if (status.rd_free) begin
          cmd.act    = vpa_pkg::A_MERGE_NEXT;
          phase_next = 1'b0;
          state_next = S_U_CHK;
        end else begin
          state_next = S_F_PCHK;
        end
      end
      S_U_CHK: begin
        if (status.shu_more) begin
          cmd.rd     = vpa_pkg::RD_ABOVE;
          state_next = S_U_WR;
        end else begin
          cmd.act    = vpa_pkg::A_COUNT_DEC;
          state_next = phase ? S_FIN_FREE : S_F_PCHK;
        end
      end
      S_U_WR: begin
        cmd.wr     = vpa_pkg::WR_SHIFT;
        cmd.act    = vpa_pkg::A_K_INC;
        state_next = S_U_CHK;
      end
      S_F_PCHK: begin
        if (status.has_prev) begin
          cmd.rd     = vpa_pkg::RD_PREV;
          state_next = S_F_PEV;
        end else begin
          cmd.wr     = vpa_pkg::WR_FREED;
          state_next = S_FIN_FREE;
        end
      end
      S_F_PEV: begin
        if (status.rd_free) begin
          cmd.wr     = vpa_pkg::WR_PREV;
          cmd.act    = vpa_pkg::A_K_AT_PICK;
          phase_next = 1'b1;
          state_next = S_U_CHK;
        end else begin
          cmd.wr     = vpa_pkg::WR_FREED;
          state_next = S_FIN_FREE;
        end
      end
      S_FIN_FAIL: begin
        if (status.out_free) begin
          cmd.act    = vpa_pkg::A_RES_FAIL;
          state_next = S_IDLE;
        end
      end
      S_FIN_ALLOC: begin
        if (status.out_free) begin
          cmd.act    = vpa_pkg::A_RES_ALLOC;
          state_next = S_IDLE;
        end
      end
      S_FIN_FREE: begin
        if (status.out_free) begin
          cmd.act    = vpa_pkg::A_RES_FREE;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= 1'b0;
    end else begin
      state <= state_next;
      phase <= phase_next;
    end
  end

endmodule
